// ----- rtl/utf8lw_pkg.sv -----
// Types, constants and register map of the UTF-8 greedy line wrapper.
package utf8lw_pkg;

  localparam int unsigned TEXT_BYTES_DEF = 4096;
  localparam int unsigned FIFO_DEPTH     = 4;
  localparam int unsigned MAX_RECS       = 3;

  localparam logic [1:0] REG_WIDTH_LIMIT  = 2'd0;
  localparam logic [1:0] REG_NARROW_WIDTH = 2'd1;
  localparam logic [1:0] REG_WIDE_WIDTH   = 2'd2;
  localparam logic [1:0] REG_LINE_LIMIT   = 2'd3;

  localparam logic [9:0]  WIDTH_LIMIT_RST  = 10'd204;
  localparam logic [5:0]  NARROW_WIDTH_RST = 6'd6;
  localparam logic [5:0]  WIDE_WIDTH_RST   = 6'd12;
  localparam logic [12:0] LINE_LIMIT_RST   = 13'd256;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;

  localparam logic [11:0] BYTES_MAX  = 12'hFFF;
  localparam logic [9:0]  PIXELS_MAX = 10'h3FF;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [9:0]  width_limit;
    logic [5:0]  narrow_width;
    logic [5:0]  wide_width;
    logic [12:0] line_limit;
  } cfg_t;

  typedef struct packed {
    logic        record_kind;
    logic [12:0] total_lines;
    logic [9:0]  line_pixels;
    logic [11:0] line_bytes;
    logic [11:0] line_start;
  } rec_t;

endpackage

// ----- rtl/utf8lw_step.sv -----
// Text state of the wrapper and the per-byte update that yields up to three records.
module utf8lw_step #(
  parameter int unsigned TEXT_BYTES = utf8lw_pkg::TEXT_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  utf8lw_pkg::cfg_t    cfg_i,
  output logic [2:0]          rec_vld_o,
  output utf8lw_pkg::rec_t    rec_o [3]
);
  import utf8lw_pkg::*;

  localparam int unsigned PosW = $clog2(TEXT_BYTES + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic            open_q, open_d;
  logic [11:0]     start_q, start_d;
  logic [11:0]     bytes_q, bytes_d;
  logic [9:0]      pix_q, pix_d;
  logic [1:0]      tail_q, tail_d;
  logic [12:0]     lines_q, lines_d;
  logic            ovf_q, ovf_d;

  logic [5:0]      w;
  logic [1:0]      extra;
  logic [10:0]     pix_sum;
  logic [PosW-1:0] pos_inc;

  always_comb begin
    pos_d   = pos_q;
    open_d  = open_q;
    start_d = start_q;
    bytes_d = bytes_q;
    pix_d   = pix_q;
    tail_d  = tail_q;
    lines_d = lines_q;
    ovf_d   = ovf_q;
    rec_vld_o = 3'b000;
    rec_o[0]  = '0;
    rec_o[1]  = '0;
    rec_o[2]  = '0;
    w       = cfg_i.narrow_width;
    extra   = 2'd0;
    pix_sum = '0;
    pos_inc = pos_q + PosW'(1);

    if (!ovf_q) begin
      pos_d = pos_inc;
      if (pos_inc >= PosW'(TEXT_BYTES)) begin
        ovf_d = 1'b1;
      end
      if (tail_q != 2'd0) begin
        tail_d = tail_q - 2'd1;
        if (open_q && bytes_q != BYTES_MAX) begin
          bytes_d = bytes_q + 12'd1;
        end
      end else if (data_byte_i == CHAR_CR || data_byte_i == CHAR_LF) begin
        if (open_q) begin
          lines_d   = lines_q + 13'd1;
          rec_vld_o[0] = 1'b1;
          rec_o[0]  = '{KIND_LINE, lines_d, pix_q, bytes_q, start_q};
          open_d    = 1'b0;
          start_d   = '0;
          bytes_d   = '0;
          pix_d     = '0;
        end
      end else begin
        if ((data_byte_i & LEAD2_MASK) == LEAD2_CODE) begin
          w     = cfg_i.wide_width;
          extra = 2'd1;
        end else if ((data_byte_i & LEAD3_MASK) == LEAD3_CODE) begin
          w     = cfg_i.wide_width;
          extra = 2'd2;
        end
        // wrap before a character that does not fit
        if (open_q && bytes_q != 12'd0 &&
            ({1'b0, pix_q} + 11'(w)) > {1'b0, cfg_i.width_limit}) begin
          lines_d   = lines_q + 13'd1;
          rec_vld_o[0] = 1'b1;
          rec_o[0]  = '{KIND_LINE, lines_d, pix_q, bytes_q, start_q};
          open_d    = 1'b0;
          start_d   = '0;
          bytes_d   = '0;
          pix_d     = '0;
        end
        if (!open_d && lines_d < cfg_i.line_limit) begin
          open_d  = 1'b1;
          start_d = 12'(pos_q);
          bytes_d = '0;
          pix_d   = '0;
        end
        if (open_d) begin
          pix_sum = {1'b0, pix_d} + 11'(w);
          pix_d   = pix_sum[10] ? PIXELS_MAX : pix_sum[9:0];
          if (bytes_d != BYTES_MAX) begin
            bytes_d = bytes_d + 12'd1;
          end
          tail_d = extra;
        end else begin
          tail_d = 2'd0;
        end
      end
    end

    if (last_byte_i) begin
      if (open_d) begin
        lines_d      = lines_d + 13'd1;
        rec_vld_o[1] = 1'b1;
        rec_o[1]     = '{KIND_LINE, lines_d, pix_d, bytes_d, start_d};
      end
      rec_vld_o[2] = 1'b1;
      rec_o[2]     = '{KIND_END, lines_d, 10'd0, 12'd0, 12'd0};
      pos_d   = '0;
      open_d  = 1'b0;
      start_d = '0;
      bytes_d = '0;
      pix_d   = '0;
      tail_d  = '0;
      lines_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      open_q  <= 1'b0;
      start_q <= '0;
      bytes_q <= '0;
      pix_q   <= '0;
      tail_q  <= '0;
      lines_q <= '0;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      open_q  <= open_d;
      start_q <= start_d;
      bytes_q <= bytes_d;
      pix_q   <= pix_d;
      tail_q  <= tail_d;
      lines_q <= lines_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ----- rtl/utf8lw_fifo.sv -----
// Small queue: up to three records in per cycle, one beat out per cycle on out_ready_i.
module utf8lw_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       push_vld_i,
  input  utf8lw_pkg::rec_t push_rec_i [3],
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output utf8lw_pkg::rec_t out_rec_o
);
  import utf8lw_pkg::*;

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  rec_t            mem_q [FIFO_DEPTH];
  rec_t            mem_d [FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = cnt_q != '0;
  assign out_rec_o   = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = cnt_q <= CntW'(FIFO_DEPTH - MAX_RECS);

  always_comb begin
    mem_d = mem_q;
    wr_d  = wr_q;
    for (int i = 0; i < MAX_RECS; i++) begin
      if (push_vld_i[i]) begin
        mem_d[wr_d] = push_rec_i[i];
        wr_d        = wr_d + PtrW'(1);
      end
    end
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'($countones(push_vld_i)) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    mem_q <= mem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/utf8_greedy_line_wrap.sv -----
// Top level: UTF-8 greedy line wrapper with stream ports and APB register port.
// Records of a byte are written into the queue when the byte is accepted and leave from its head.
// Throughput: one byte per cycle while the output drains; a byte yields up to three beats,
// which leave one per cycle while m_axis_tready is high, from a four-entry queue;
// s_axis_tready is low while it holds two or more.
// Reset: text state and queue cleared, registers return to their defaults.
module utf8_greedy_line_wrap #(
  parameter int unsigned TEXT_BYTES = utf8lw_pkg::TEXT_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] line_start, [23:12] line_bytes, [33:24] line_pixels, [46:34] total_lines
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser,  // [0] record_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import utf8lw_pkg::*;

  cfg_t       cfg_q;
  logic       accept;
  logic       room;
  logic [2:0] rec_vld;
  rec_t       recs [3];
  rec_t       head;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_limit  <= WIDTH_LIMIT_RST;
      cfg_q.narrow_width <= NARROW_WIDTH_RST;
      cfg_q.wide_width   <= WIDE_WIDTH_RST;
      cfg_q.line_limit   <= LINE_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WIDTH_LIMIT:  cfg_q.width_limit  <= pwdata[9:0];
        REG_NARROW_WIDTH: cfg_q.narrow_width <= pwdata[5:0];
        REG_WIDE_WIDTH:   cfg_q.wide_width   <= pwdata[5:0];
        REG_LINE_LIMIT:   cfg_q.line_limit   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH_LIMIT:  prdata = 32'(cfg_q.width_limit);
      REG_NARROW_WIDTH: prdata = 32'(cfg_q.narrow_width);
      REG_WIDE_WIDTH:   prdata = 32'(cfg_q.wide_width);
      REG_LINE_LIMIT:   prdata = 32'(cfg_q.line_limit);
      default:          prdata = '0;
    endcase
  end

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  utf8lw_step #(
    .TEXT_BYTES(TEXT_BYTES)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(s_axis_tdata),
    .last_byte_i(s_axis_tlast),
    .cfg_i      (cfg_q),
    .rec_vld_o  (rec_vld),
    .rec_o      (recs)
  );

  utf8lw_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_vld_i (accept ? rec_vld : 3'b000),
    .push_rec_i (recs),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_rec_o  (head)
  );

  assign m_axis_tdata = {1'b0, head.total_lines, head.line_pixels,
                         head.line_bytes, head.line_start};
  assign m_axis_tuser = head.record_kind;

endmodule

// ----- rtl/utf8lw_checker.sv -----
// Port-level checker for the line wrapper, bound to the top level.
module utf8lw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import utf8lw_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tdata[33:0] == '0)
    else $error("end record carries line fields");

  a_line_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_LINE |->
      m_axis_tdata[23:12] != '0 && m_axis_tdata[46:34] != '0)
    else $error("line record with no bytes or zero line count");

  a_no_beat_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output beat straight after reset");

endmodule

bind utf8_greedy_line_wrap utf8lw_checker u_utf8lw_checker (.*);
